// ===== rtl/fuzzy_pd_controller_defines.svh =====
// Assertion macros for the fuzzy PD controller checker
`ifndef FUZZY_PD_CONTROLLER_DEFINES_SVH
`define FUZZY_PD_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define FPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpd assertion failed");

// next-cycle implication
`define FPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpd assertion failed");

`endif

// ===== rtl/fpd_pkg.sv =====
// Types, constants and tables for the fuzzy PD controller
package fpd_pkg;

  localparam int FRAC_BITS = 8;
  localparam int ERR_N     = 7;
  localparam int RATE_N    = 5;
  localparam int IN_W      = 20;
  localparam int NUM_W     = 24;
  localparam int DEN_W     = 8;
  localparam int DEG_W     = 16;
  localparam int WGT_W     = 17;
  localparam int CTR_W     = 13;
  localparam int RULE_W    = 3;
  localparam int ACC_W     = 30;
  localparam int SUM_W     = 18;
  localparam int Q16_SHIFT = 17;

  localparam logic [WGT_W-1:0] ONE_Q16 = 17'd65536;

  typedef logic signed [10:0] half_t;

  localparam half_t ERR_HALF [2][ERR_N] = '{
    '{-11'sd50, -11'sd25, -11'sd12, 11'sd0, 11'sd12, 11'sd25, 11'sd50},
    '{-11'sd500, -11'sd300, -11'sd100, 11'sd0, 11'sd100, 11'sd300, 11'sd500}
  };

  localparam half_t RATE_HALF [2][RATE_N] = '{
    '{-11'sd16, -11'sd8, 11'sd0, 11'sd8, 11'sd16},
    '{-11'sd100, -11'sd60, 11'sd0, 11'sd60, 11'sd100}
  };

  localparam logic [CTR_W-1:0] CENTRE [2][7] = '{
    '{13'd0, 13'd307, 13'd614, 13'd1229, 13'd1536, 13'd1920, 13'd2304},
    '{13'd0, 13'd1024, 13'd2048, 13'd3072, 13'd4352, 13'd5632, 13'd7680}
  };

  localparam logic [RULE_W-1:0] RULE [2][ERR_N][RATE_N] = '{
    '{
      '{3'd1, 3'd1, 3'd1, 3'd0, 3'd0},
      '{3'd4, 3'd2, 3'd1, 3'd0, 3'd0},
      '{3'd6, 3'd5, 3'd1, 3'd1, 3'd0},
      '{3'd4, 3'd3, 3'd0, 3'd3, 3'd4},
      '{3'd0, 3'd1, 3'd1, 3'd5, 3'd6},
      '{3'd0, 3'd0, 3'd1, 3'd2, 3'd4},
      '{3'd0, 3'd0, 3'd1, 3'd1, 3'd1}
    },
    '{
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd1, 3'd2, 3'd6, 3'd5, 3'd3},
      '{3'd1, 3'd2, 3'd5, 3'd4, 3'd2},
      '{3'd1, 3'd2, 3'd4, 3'd2, 3'd1},
      '{3'd1, 3'd3, 3'd2, 3'd1, 3'd0}
    }
  };

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [2:0]       upper;
    logic             clamp_lo;
  } axis_t;

  typedef struct packed {
    logic       sel;
    logic [2:0] upper;
    logic       clamp_lo;
  } err_side_t;

  typedef struct packed {
    logic [2:0] upper;
    logic       clamp_lo;
  } rate_side_t;

  function automatic logic [WGT_W-1:0] wmin(input logic [WGT_W-1:0] a,
                                            input logic [WGT_W-1:0] b);
    return (a <= b) ? a : b;
  endfunction

endpackage

// ===== rtl/fpd_fuzz.sv =====
// Segment search and degree numerator/denominator for both inputs
module fpd_fuzz #(
  parameter int FRAC_BITS = fpd_pkg::FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [fpd_pkg::IN_W-1:0]  error,
  input  logic signed [fpd_pkg::IN_W-1:0]  error_rate,
  input  logic                             sel,
  output logic                             valid,
  output fpd_pkg::axis_t                   e_axis,
  output fpd_pkg::axis_t                   r_axis,
  output logic                             sel_out
);

  localparam int CW = (FRAC_BITS + 11 > fpd_pkg::IN_W + 1) ? FRAC_BITS + 11
                                                           : fpd_pkg::IN_W + 1;
  localparam int SH = fpd_pkg::Q16_SHIFT - FRAC_BITS;

  fpd_pkg::axis_t e_next, r_next;

  function automatic logic signed [CW-1:0] scale(input fpd_pkg::half_t h);
    return CW'(h) <<< (FRAC_BITS - 1);
  endfunction

  always_comb begin
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] diff;
    logic [fpd_pkg::DEN_W-1:0] wd;
    x    = CW'(error);
    diff = '0;
    wd   = fpd_pkg::DEN_W'(1);
    e_next.upper    = 3'd1;
    e_next.clamp_lo = 1'b1;
    e_next.num      = '0;
    e_next.den      = fpd_pkg::DEN_W'(1);
    if (x <= scale(fpd_pkg::ERR_HALF[sel][0])) begin
      e_next.clamp_lo = 1'b1;
    end else if (x >= scale(fpd_pkg::ERR_HALF[sel][fpd_pkg::ERR_N-1])) begin
      e_next.upper    = 3'(fpd_pkg::ERR_N - 1);
      e_next.clamp_lo = 1'b0;
    end else begin
      e_next.clamp_lo = 1'b0;
      for (int k = fpd_pkg::ERR_N - 1; k >= 1; k--) begin
        if (x <= scale(fpd_pkg::ERR_HALF[sel][k])) begin
          e_next.upper = 3'(k);
          diff = scale(fpd_pkg::ERR_HALF[sel][k]) - x;
          wd   = fpd_pkg::DEN_W'(fpd_pkg::ERR_HALF[sel][k] - fpd_pkg::ERR_HALF[sel][k-1]);
        end
      end
      e_next.num = fpd_pkg::NUM_W'(unsigned'(diff)) << SH;
      e_next.den = wd;
    end
  end

  always_comb begin
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] diff;
    logic [fpd_pkg::DEN_W-1:0] wd;
    x    = CW'(error_rate);
    diff = '0;
    wd   = fpd_pkg::DEN_W'(1);
    r_next.upper    = 3'd1;
    r_next.clamp_lo = 1'b1;
    r_next.num      = '0;
    r_next.den      = fpd_pkg::DEN_W'(1);
    if (x <= scale(fpd_pkg::RATE_HALF[sel][0])) begin
      r_next.clamp_lo = 1'b1;
    end else if (x >= scale(fpd_pkg::RATE_HALF[sel][fpd_pkg::RATE_N-1])) begin
      r_next.upper    = 3'(fpd_pkg::RATE_N - 1);
      r_next.clamp_lo = 1'b0;
    end else begin
      r_next.clamp_lo = 1'b0;
      for (int k = fpd_pkg::RATE_N - 1; k >= 1; k--) begin
        if (x <= scale(fpd_pkg::RATE_HALF[sel][k])) begin
          r_next.upper = 3'(k);
          diff = scale(fpd_pkg::RATE_HALF[sel][k]) - x;
          wd   = fpd_pkg::DEN_W'(fpd_pkg::RATE_HALF[sel][k] - fpd_pkg::RATE_HALF[sel][k-1]);
        end
      end
      r_next.num = fpd_pkg::NUM_W'(unsigned'(diff)) << SH;
      r_next.den = wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_axis  <= e_next;
      r_axis  <= r_next;
      sel_out <= sel;
    end
  end

endmodule

// ===== rtl/fpd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
module fpd_div #(
  parameter int NW = 24,
  parameter int DW = 8,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  localparam int TW = (NW > DW + QW) ? NW : DW + QW;

  logic          v  [QW];
  logic [NW-1:0] r  [QW];
  logic [DW-1:0] d  [QW];
  logic [QW-1:0] q  [QW];
  logic [SW-1:0] sd [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int B = QW - 1 - i;
    logic          sv;
    logic [NW-1:0] sr;
    logic [DW-1:0] sdn;
    logic [QW-1:0] sq;
    logic [SW-1:0] ss;
    logic [TW-1:0] trial;
    logic          take;

    if (i == 0) begin : g_first
      assign sv  = in_valid;
      assign sr  = num;
      assign sdn = den;
      assign sq  = '0;
      assign ss  = side_in;
    end else begin : g_rest
      assign sv  = v[i-1];
      assign sr  = r[i-1];
      assign sdn = d[i-1];
      assign sq  = q[i-1];
      assign ss  = sd[i-1];
    end

    assign trial = TW'(sdn) << B;
    assign take  = TW'(sr) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[i]  <= take ? NW'(TW'(sr) - trial) : sr;
        d[i]  <= sdn;
        q[i]  <= sq | (QW'(take) << B);
        sd[i] <= ss;
      end
    end
  end

  assign out_valid = v[QW-1];
  assign quo       = q[QW-1];
  assign side_out  = sd[QW-1];

endmodule

// ===== rtl/fpd_rules.sv =====
// Rule lookup, weight pruning and weighted sums
module fpd_rules (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [fpd_pkg::DEG_W-1:0]     e_quo,
  input  fpd_pkg::err_side_t            e_side,
  input  logic [fpd_pkg::DEG_W-1:0]     r_quo,
  input  fpd_pkg::rate_side_t           r_side,
  output logic                          valid,
  output logic [fpd_pkg::ACC_W-1:0]     num,
  output logic [fpd_pkg::SUM_W-1:0]     den
);

  localparam int WW = fpd_pkg::WGT_W;

  logic          v1, v2, v3;
  logic [WW-1:0] w1 [4];
  logic [2:0]    o1 [4];
  logic          s1;
  logic [WW-1:0] w2 [4];
  logic [2:0]    o2 [4];
  logic          s2;
  logic [fpd_pkg::ACC_W-1:0] p3 [4];
  logic [WW-1:0] w3 [4];

  logic [WW-1:0] w1_next [4];
  logic [2:0]    o1_next [4];
  logic [WW-1:0] w2_next [4];

  always_comb begin
    logic [WW-1:0] p0, p1, d0, d1;
    logic [2:0] pu, du;
    p0 = e_side.clamp_lo ? fpd_pkg::ONE_Q16 : {1'b0, e_quo};
    d0 = r_side.clamp_lo ? fpd_pkg::ONE_Q16 : {1'b0, r_quo};
    p1 = fpd_pkg::ONE_Q16 - p0;
    d1 = fpd_pkg::ONE_Q16 - d0;
    pu = e_side.upper;
    du = r_side.upper;
    o1_next[0] = fpd_pkg::RULE[e_side.sel][pu - 3'd1][du - 3'd1];
    o1_next[1] = fpd_pkg::RULE[e_side.sel][pu][du - 3'd1];
    o1_next[2] = fpd_pkg::RULE[e_side.sel][pu - 3'd1][du];
    o1_next[3] = fpd_pkg::RULE[e_side.sel][pu][du];
    w1_next[0] = fpd_pkg::wmin(p0, d0);
    w1_next[1] = fpd_pkg::wmin(p1, d0);
    w1_next[2] = fpd_pkg::wmin(p0, d1);
    w1_next[3] = fpd_pkg::wmin(p1, d1);
  end

  // pairs in order, each seeing earlier zeroings
  always_comb begin
    w2_next = w1;
    for (int i = 0; i < 3; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        if (o1[i] == o1[j]) begin
          if (w2_next[i] > w2_next[j]) begin
            w2_next[j] = '0;
          end else begin
            w2_next[i] = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1 <= w1_next;
      o1 <= o1_next;
      s1 <= e_side.sel;
      w2 <= w2_next;
      o2 <= o1;
      s2 <= s1;
      for (int i = 0; i < 4; i++) begin
        p3[i] <= fpd_pkg::ACC_W'(w2[i]) *
                 fpd_pkg::ACC_W'(fpd_pkg::CENTRE[s2][o2[i]]);
        w3[i] <= w2[i];
      end
      num <= p3[0] + p3[1] + p3[2] + p3[3];
      den <= fpd_pkg::SUM_W'(w3[0]) + fpd_pkg::SUM_W'(w3[1]) +
             fpd_pkg::SUM_W'(w3[2]) + fpd_pkg::SUM_W'(w3[3]);
    end
  end

endmodule

// ===== rtl/fuzzy_pd_controller.sv =====
// Top level of the fuzzy PD controller with weighted-average output
//
//  channel  | valid      | ready      | payload
//  ---------+------------+------------+------------------------
//  input    | in_valid   | in_ready   | error, error_rate
//  output   | out_valid  | out_ready  | drive
//  config   | cfg_valid  | cfg_ready  | table_select
//
// One request per cycle unless the output stalls; pipeline of 1 fuzzify, 16 degree
// divider, 4 rule/sum and 13 output divider stages.
// The whole pipeline advances together whenever the output stage is empty
// or being taken; a stall freezes every stage.
// Synchronous reset clears valid bits and table_select to steering.
module fuzzy_pd_controller #(
  parameter int FRAC_BITS = fpd_pkg::FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [fpd_pkg::IN_W-1:0] error,
  input  logic signed [fpd_pkg::IN_W-1:0] error_rate,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fpd_pkg::CTR_W-1:0]       drive,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            table_select
);

  logic en;
  logic table_sel;

  logic           f_valid, f_sel;
  fpd_pkg::axis_t e_axis, r_axis;

  logic                         de_valid, dr_valid;
  logic [fpd_pkg::DEG_W-1:0]    e_quo, r_quo;
  fpd_pkg::err_side_t           e_side_in, e_side;
  fpd_pkg::rate_side_t          r_side_in, r_side;

  logic                         s_valid;
  logic [fpd_pkg::ACC_W-1:0]    s_num;
  logic [fpd_pkg::SUM_W-1:0]    s_den;

  logic [fpd_pkg::CTR_W-1:0]    quo;
  logic                         zero_sum;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_sel <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      table_sel <= table_select;
    end
  end

  fpd_fuzz #(.FRAC_BITS(FRAC_BITS)) u_fuzz (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .error      (error),
    .error_rate (error_rate),
    .sel        (table_sel),
    .valid      (f_valid),
    .e_axis     (e_axis),
    .r_axis     (r_axis),
    .sel_out    (f_sel)
  );

  assign e_side_in = '{sel: f_sel, upper: e_axis.upper, clamp_lo: e_axis.clamp_lo};
  assign r_side_in = '{upper: r_axis.upper, clamp_lo: r_axis.clamp_lo};

  fpd_div #(
    .NW (fpd_pkg::NUM_W),
    .DW (fpd_pkg::DEN_W),
    .QW (fpd_pkg::DEG_W),
    .SW ($bits(fpd_pkg::err_side_t))
  ) u_div_err (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       (e_axis.num),
    .den       (e_axis.den),
    .side_in   (e_side_in),
    .out_valid (de_valid),
    .quo       (e_quo),
    .side_out  (e_side)
  );

  fpd_div #(
    .NW (fpd_pkg::NUM_W),
    .DW (fpd_pkg::DEN_W),
    .QW (fpd_pkg::DEG_W),
    .SW ($bits(fpd_pkg::rate_side_t))
  ) u_div_rate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       (r_axis.num),
    .den       (r_axis.den),
    .side_in   (r_side_in),
    .out_valid (dr_valid),
    .quo       (r_quo),
    .side_out  (r_side)
  );

  fpd_rules u_rules (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (de_valid && dr_valid),
    .e_quo    (e_quo),
    .e_side   (e_side),
    .r_quo    (r_quo),
    .r_side   (r_side),
    .valid    (s_valid),
    .num      (s_num),
    .den      (s_den)
  );

  fpd_div #(
    .NW (fpd_pkg::ACC_W),
    .DW (fpd_pkg::SUM_W),
    .QW (fpd_pkg::CTR_W),
    .SW (1)
  ) u_div_out (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .num       (s_num),
    .den       (s_den),
    .side_in   (s_den == '0),
    .out_valid (out_valid),
    .quo       (quo),
    .side_out  (zero_sum)
  );

  assign drive = zero_sum ? '0 : quo;

endmodule

// ===== rtl/fpd_chk.sv =====
// Port-level checks for the fuzzy PD controller, bound to the top level
`include "fuzzy_pd_controller_defines.svh"

module fpd_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [fpd_pkg::CTR_W-1:0] drive
);

  `FPD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(drive))
  `FPD_ASSERT_NOW(a_drive_range, clk, rst, out_valid, drive <= 13'd7680)
  `FPD_ASSERT_NOW(a_stall_blocks_in, clk, rst, out_valid && !out_ready, !in_ready)
  `FPD_ASSERT_NOW(a_empty_takes_in, clk, rst, !out_valid, in_ready)

endmodule

bind fuzzy_pd_controller fpd_chk u_chk (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the fuzzy PD controller
module tb_top;

  localparam int WATCHDOG = 20000;
  localparam int LATENCY  = 34;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [fpd_pkg::IN_W-1:0] error = '0;
  logic signed [fpd_pkg::IN_W-1:0] error_rate = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [fpd_pkg::CTR_W-1:0] drive;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic table_select = 1'b0;

  int mismatches = 0;
  int idle_cycles = 0;
  int results_seen = 0;
  bit quiet = 1'b0;
  bit sink_idle_en = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fuzzy_pd_controller uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .error(error), .error_rate(error_rate),
    .out_valid(out_valid), .out_ready(out_ready), .drive(drive),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .table_select(table_select)
  );

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  class drive_scoreboard;
    logic [fpd_pkg::CTR_W-1:0] pending_drive[$];
    bit speed;

    function automatic void membership(input longint x, input bit is_err,
                                       output int upper, output longint deg_lo);
      int n;
      int k;
      longint hi, lo;
      longint pts[7];
      n = is_err ? fpd_pkg::ERR_N : fpd_pkg::RATE_N;
      for (int i = 0; i < n; i++)
        pts[i] = is_err
          ? longint'(fpd_pkg::ERR_HALF[speed][i]) * (1 << (fpd_pkg::FRAC_BITS - 1))
          : longint'(fpd_pkg::RATE_HALF[speed][i]) * (1 << (fpd_pkg::FRAC_BITS - 1));
      if (x <= pts[0]) begin
        upper = 1; deg_lo = 65536; return;
      end
      if (x >= pts[n-1]) begin
        upper = n - 1; deg_lo = 0; return;
      end
      for (k = 1; k < n - 1; k++) if (x <= pts[k]) break;
      hi = pts[k];
      lo = pts[k-1];
      upper = k;
      deg_lo = ((hi - x) * 65536) / (hi - lo);
    endfunction

    function automatic void note_request(input logic signed [fpd_pkg::IN_W-1:0] e,
                                         input logic signed [fpd_pkg::IN_W-1:0] r);
      int pu, du;
      longint p0, d0, p1, d1, num, den;
      longint w[4];
      int o[4];
      membership(longint'(e), 1'b1, pu, p0);
      membership(longint'(r), 1'b0, du, d0);
      p1 = 65536 - p0;
      d1 = 65536 - d0;
      o[0] = fpd_pkg::RULE[speed][pu-1][du-1];
      o[1] = fpd_pkg::RULE[speed][pu][du-1];
      o[2] = fpd_pkg::RULE[speed][pu-1][du];
      o[3] = fpd_pkg::RULE[speed][pu][du];
      w[0] = (p0 <= d0) ? p0 : d0;
      w[1] = (p1 <= d0) ? p1 : d0;
      w[2] = (p0 <= d1) ? p0 : d1;
      w[3] = (p1 <= d1) ? p1 : d1;
      for (int i = 0; i < 3; i++)
        for (int j = i + 1; j < 4; j++)
          if (o[i] == o[j]) begin
            if (w[i] > w[j]) w[j] = 0;
            else w[i] = 0;
          end
      num = 0;
      den = 0;
      for (int i = 0; i < 4; i++) begin
        num += w[i] * fpd_pkg::CENTRE[speed][o[i] % 7];
        den += w[i];
      end
      pending_drive.push_back(den == 0 ? '0 : fpd_pkg::CTR_W'(num / den));
    endfunction

    task automatic check_result(input logic [fpd_pkg::CTR_W-1:0] got);
      logic [fpd_pkg::CTR_W-1:0] want;
      if (pending_drive.size() == 0) begin
        report("unexpected drive", got, -1);
        return;
      end
      want = pending_drive.pop_front();
      if (got !== want) report("drive", got, want);
    endtask
  endclass

  drive_scoreboard sb = new();

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_valid && in_ready) sb.note_request(error, error_rate);
      if (out_valid && out_ready) begin
        sb.check_result(drive);
        results_seen++;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // output-side stalls
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (sink_idle_en && !quiet) begin
        gap = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic send(input logic signed [fpd_pkg::IN_W-1:0] e,
                      input logic signed [fpd_pkg::IN_W-1:0] r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    error <= e;
    error_rate <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_mode(input bit mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_drive.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    table_select <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.speed = mode;
  endtask

  function automatic logic signed [fpd_pkg::IN_W-1:0] near_point(input bit is_err,
                                                                 input bit mode);
    int idx;
    longint p;
    idx = is_err ? $urandom_range(0, fpd_pkg::ERR_N - 1)
                 : $urandom_range(0, fpd_pkg::RATE_N - 1);
    p = is_err ? longint'(fpd_pkg::ERR_HALF[mode][idx])
               : longint'(fpd_pkg::RATE_HALF[mode][idx]);
    p = p * (1 << (fpd_pkg::FRAC_BITS - 1)) + $signed($urandom_range(0, 6)) - 3;
    return fpd_pkg::IN_W'(p);
  endfunction

  function automatic logic signed [fpd_pkg::IN_W-1:0] pick(input bit is_err,
                                                           input bit mode);
    int lim;
    case ($urandom_range(0, 9))
      0: return fpd_pkg::IN_W'($urandom);
      1, 2: return near_point(is_err, mode);
      default: begin
        lim = is_err ? (mode ? 70000 : 7000) : (mode ? 14000 : 2200);
        return fpd_pkg::IN_W'($signed($urandom_range(0, 2 * lim)) - lim);
      end
    endcase
  endfunction

  function automatic logic signed [fpd_pkg::IN_W-1:0] at_point(input bit is_err,
                                                               input int mode,
                                                               input int idx,
                                                               input int offs);
    longint p;
    p = is_err ? longint'(fpd_pkg::ERR_HALF[mode][idx])
               : longint'(fpd_pkg::RATE_HALF[mode][idx]);
    p = p * (1 << (fpd_pkg::FRAC_BITS - 1)) + offs;
    return fpd_pkg::IN_W'(p);
  endfunction

  initial begin
    logic signed [fpd_pkg::IN_W-1:0] ext [6];
    int n;
    ext = '{20'sh80000, 20'sh7FFFF, 20'sd0, -20'sd1, 20'sd1, 20'sd256};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int m = 0; m < 2; m++) begin
      write_mode(m[0]);
      for (int i = 0; i < 6; i++) send(ext[i], ext[(i + 2) % 6]);
      send(at_point(1'b1, m, 2, 0), at_point(1'b0, m, 1, 0));
      send(at_point(1'b1, m, 0, 0), at_point(1'b0, m, 4, 0));
      send(at_point(1'b1, m, 6, 0), at_point(1'b0, m, 0, 0));
      send(at_point(1'b1, m, 4, 1), at_point(1'b0, m, 3, -1));
      send(at_point(1'b1, m, 3, 0), at_point(1'b0, m, 2, 0));
    end

    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0] ^ ph[1]);
      if (ph == 3) quiet = 1'b1;
      for (int i = 0; i < 460; i++) begin
        send(pick(1'b1, sb.speed), pick(1'b0, sb.speed));
        n++;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_drive.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (out_valid) report("extra drive after drain", drive, -1);

    $display("covered %0d random requests plus directed corners, both table sets", n);
    $display("%0d drive results compared", results_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fpd_pkg.sv
rtl/fpd_fuzz.sv
rtl/fpd_div.sv
rtl/fpd_rules.sv
rtl/fuzzy_pd_controller.sv
rtl/fpd_chk.sv
dv/tb_top.sv
